// ===== rtl/core/ntcavg_pkg.sv =====
package ntcavg_pkg;

	// Field widths
	localparam int LEVEL_W   = 12;
	localparam int TEMP_W    = 9;
	localparam int OFFSET_W  = 8;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;
	localparam int ALU_W     = 12;
	localparam int TBL_IDX_W = 8;

	// Defaults for the top-level parameters
	localparam int RING_DEPTH_DEF    = 8;
	localparam int TABLE_ENTRIES_DEF = 190;

	// Reset values
	localparam logic [LEVEL_W-1:0]  PRESET_LEVEL = 12'd1650;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd51;

	// Thermistor voltage curve, -51 to 138 degrees at the reset offset, decreasing
	localparam int TABLE_FIXED = 190;
	localparam logic [LEVEL_W-1:0] VOLT_TABLE [0:TABLE_FIXED-1] = '{
		12'd3937,
		12'd3927, 12'd3917, 12'd3906, 12'd3895, 12'd3883, 12'd3870, 12'd3857, 12'd3843,
		12'd3829, 12'd3814,
		12'd3799, 12'd3783, 12'd3766, 12'd3748, 12'd3730, 12'd3711, 12'd3691, 12'd3671,
		12'd3650, 12'd3628,
		12'd3605, 12'd3582, 12'd3558, 12'd3533, 12'd3508, 12'd3481, 12'd3454, 12'd3426,
		12'd3398, 12'd3369,
		12'd3338, 12'd3308, 12'd3276, 12'd3244, 12'd3211, 12'd3178, 12'd3144, 12'd3109,
		12'd3074, 12'd3038,
		12'd3001, 12'd2965, 12'd2927, 12'd2889, 12'd2851, 12'd2812, 12'd2773, 12'd2734,
		12'd2694, 12'd2654,
		12'd2614, 12'd2574, 12'd2533, 12'd2493, 12'd2452, 12'd2411, 12'd2370, 12'd2330,
		12'd2289, 12'd2248,
		12'd2208, 12'd2167, 12'd2127, 12'd2087, 12'd2048, 12'd2008, 12'd1969, 12'd1930,
		12'd1892, 12'd1853,
		12'd1816, 12'd1778, 12'd1741, 12'd1705, 12'd1669, 12'd1633, 12'd1598, 12'd1564,
		12'd1529, 12'd1496,
		12'd1463, 12'd1430, 12'd1398, 12'd1367, 12'd1336, 12'd1306, 12'd1276, 12'd1247,
		12'd1218, 12'd1190,
		12'd1163, 12'd1136, 12'd1109, 12'd1083, 12'd1058, 12'd1033, 12'd1009, 12'd985,
		12'd962, 12'd940,
		12'd917, 12'd896, 12'd875, 12'd854, 12'd834, 12'd814, 12'd795, 12'd776,
		12'd757, 12'd740,
		12'd722, 12'd705, 12'd688, 12'd672, 12'd656, 12'd641, 12'd626, 12'd611,
		12'd597, 12'd583,
		12'd569, 12'd556, 12'd543, 12'd530, 12'd518, 12'd506, 12'd495, 12'd483,
		12'd472, 12'd461,
		12'd451, 12'd440, 12'd430, 12'd421, 12'd411, 12'd402, 12'd393, 12'd384,
		12'd376, 12'd367,
		12'd359, 12'd351, 12'd343, 12'd336, 12'd328, 12'd321, 12'd314, 12'd307,
		12'd301, 12'd294,
		12'd288, 12'd282, 12'd276, 12'd270, 12'd264, 12'd259, 12'd253, 12'd248,
		12'd243, 12'd238,
		12'd233, 12'd228, 12'd223, 12'd219, 12'd214, 12'd210, 12'd205, 12'd200,
		12'd195, 12'd190,
		12'd186, 12'd182, 12'd178, 12'd175, 12'd172, 12'd168, 12'd165, 12'd162,
		12'd159, 12'd156,
		12'd153, 12'd150, 12'd147, 12'd144, 12'd142, 12'd139, 12'd136, 12'd134,
		12'd131
	};

	// Positions past the fixed curve read as zero, so they always match
	function automatic logic [LEVEL_W-1:0] volt_level(input logic [TBL_IDX_W-1:0] idx);
		logic [LEVEL_W-1:0] lvl;
		lvl = '0;
		if (int'(idx) < TABLE_FIXED) begin
			lvl = VOLT_TABLE[idx];
		end
		return lvl;
	endfunction

endpackage

// ===== rtl/core/ntcavg_ram.sv =====
module ntcavg_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ntcavg_alu.sv =====
module ntcavg_alu (
	input  logic [ntcavg_pkg::ALU_W-1:0] a,
	input  logic [ntcavg_pkg::ALU_W-1:0] b,
	output logic                         geq
);

	import ntcavg_pkg::*;

	// Unsigned compare; high when a is at or above b
	assign geq = (a >= b);

endmodule

// ===== rtl/core/ntc_average_temperature_lookup_top.sv =====
// An accepted request passes through the read, average and search states; the search
// takes up to ceil(log2(TABLE_ENTRIES+1)) steps (8 at 190 entries) and waits for a free
// output register; a non-power-of-two ring depth averages by a reciprocal multiply.
// A new request is taken only once the last result has entered the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous): ring reads as 1650, slot 0, offset 51, output empty.
module ntc_average_temperature_lookup_top #(
	parameter int RING_DEPTH    = ntcavg_pkg::RING_DEPTH_DEF,
	parameter int TABLE_ENTRIES = ntcavg_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_axis_tdata: adc_sample [11:0], zero [15:12]
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ntcavg_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// m_axis_tdata: temperature [8:0], average_level [20:9], zero [23:21]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ntcavg_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// cfg_data: index_offset [7:0]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ntcavg_pkg::OFFSET_W-1:0]  cfg_data
);

	import ntcavg_pkg::*;

	localparam int AW       = $clog2(RING_DEPTH);
	localparam int SUM_W    = LEVEL_W + AW;
	localparam int PW       = $clog2(TABLE_ENTRIES + 1);
	localparam bit POW2     = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
	localparam int RECIP_SH = SUM_W + AW;
	localparam int RECIP_W  = SUM_W + 1;
	localparam int PROD_W   = RECIP_SH + LEVEL_W;

	localparam logic [SUM_W-1:0] SUM_RESET  = SUM_W'(RING_DEPTH * int'(PRESET_LEVEL));
	localparam logic [PW-1:0]    SEARCH_TOP = PW'(TABLE_ENTRIES);

	// Rounded-up reciprocal of the ring depth, exact for every running sum
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_AVG    = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd4;

	logic [2:0]            state_q;
	logic [LEVEL_W-1:0]    sample_q;
	logic [AW-1:0]         slot_q;
	logic [RING_DEPTH-1:0] valid_q;
	logic [SUM_W-1:0]      sum_q;
	logic [LEVEL_W-1:0]    avg_q;
	logic [PW-1:0]         lo_q;
	logic [PW-1:0]         hi_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic                  m_valid_q;
	logic [TEMP_W-1:0]     temp_q;
	logic [LEVEL_W-1:0]    avg_out_q;

	logic                  s_acc;
	logic                  ram_wr;
	logic [LEVEL_W-1:0]    ram_rdata;
	logic [LEVEL_W-1:0]    old_level;
	logic [PROD_W-1:0]     quot_prod;
	logic [PW:0]           mid_sum;
	logic [PW-1:0]         mid;
	logic [ALU_W-1:0]      alu_a;
	logic [ALU_W-1:0]      alu_b;
	logic                  alu_geq;
	logic                  out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign ram_wr        = (state_q == ST_READ);
	assign out_free      = !m_valid_q || m_axis_tready;

	// Sample ring
	ntcavg_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (slot_q),
		.wr_data (sample_q),
		.rd_en   (s_acc),
		.rd_addr (slot_q),
		.rd_data (ram_rdata)
	);

	// Slots never written read as the preset level
	assign old_level = valid_q[slot_q] ? ram_rdata : PRESET_LEVEL;

	// Divide the running sum by the ring depth through its reciprocal
	assign quot_prod = PROD_W'(sum_q) * PROD_W'(RECIP);

	// Search midpoint
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[PW:1];

	// Compare unit operands
	assign alu_a = avg_q;
	assign alu_b = volt_level(TBL_IDX_W'(mid));

	ntcavg_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.geq (alu_geq)
	);

	// Offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			valid_q <= '0;
			sum_q   <= SUM_RESET;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q          <= sum_q - SUM_W'(old_level) + SUM_W'(sample_q);
					valid_q[slot_q] <= 1'b1;
					slot_q         <= (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + AW'(1);
					state_q        <= ST_AVG;
				end
				ST_AVG: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (lo_q == hi_q && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sample_q <= s_axis_tdata[LEVEL_W-1:0];
		end
		if (state_q == ST_AVG) begin
			lo_q <= '0;
			hi_q <= SEARCH_TOP;
			if (POW2) begin
				avg_q <= sum_q[AW +: LEVEL_W];
			end else begin
				avg_q <= quot_prod[RECIP_SH +: LEVEL_W];
			end
		end
		// Binary search for the first entry at or below the average
		if (state_q == ST_SEARCH && lo_q != hi_q) begin
			if (alu_geq) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + PW'(1);
			end
		end
		if (state_q == ST_SEARCH && lo_q == hi_q && out_free) begin
			temp_q    <= TEMP_W'(lo_q) - TEMP_W'(offset_q);
			avg_out_q <= avg_q;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_SEARCH && lo_q == hi_q && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W - TEMP_W - LEVEL_W)'(0), avg_out_q, temp_q};

endmodule

// ===== rtl/core/ntcavg_chk.sv =====
module ntcavg_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [ntcavg_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ntcavg_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [ntcavg_pkg::OFFSET_W-1:0]  cfg_data
);

	import ntcavg_pkg::*;

	// Busy right after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after a taken request");

	// A new result only appears while the input side is busy
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while input side was idle");

	// Padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:TEMP_W+LEVEL_W] == '0))
		else $error("result padding not zero");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind ntc_average_temperature_lookup_top ntcavg_chk u_ntcavg_chk (.*);
